[src/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, inactive while in reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, inactive while in reset.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[src/rvp_pkg.sv]
`timescale 1ns / 1ps
package rvp_pkg;

  // Datapath widths
  localparam int unsigned WORD_W     = 32;  // Q16.16 field
  localparam int unsigned EDGE_W     = 33;  // exact edge
  localparam int unsigned PROD_W     = 66;  // edge product
  localparam int unsigned CROSS_W    = 67;  // exact cross component
  localparam int unsigned MAG_W      = 66;  // cross magnitude
  localparam int unsigned M_W        = 30;  // normalised magnitude, top bit 29
  localparam int unsigned SQ_W       = 60;
  localparam int unsigned Q_W        = 62;  // sum of squares
  localparam int unsigned ROOT_W     = 31;
  localparam int unsigned REM_W      = 33;  // root remainder
  localparam int unsigned DREM_W     = 31;  // divider remainder
  localparam int unsigned QUO_W      = 29;  // normal magnitude
  localparam int unsigned NORM_BITS  = 28;
  localparam int unsigned N_W        = 30;  // signed normal component
  localparam int unsigned DOT_W      = 62;
  localparam int unsigned D_W        = 64;
  localparam int unsigned S_W        = 35;
  localparam int unsigned P_W        = 65;
  localparam int unsigned U_W        = 36;
  localparam int unsigned R_W        = 37;

  // Chain lengths
  localparam int unsigned SHIFT_STAGES = 7;
  localparam int unsigned SQRT_STEPS   = 31;
  localparam int unsigned DIV_STEPS    = 29;

  typedef logic [2:0][WORD_W-1:0] vec3_t;
  typedef logic [2:0][M_W-1:0]    m3_t;

  // Data that rides alongside the arithmetic
  typedef struct packed {
    vec3_t      vec;
    logic [2:0] neg;
    logic       deg;
  } side_t;

  typedef struct packed {
    side_t base;
    m3_t   m;
  } sq_side_t;

endpackage

[src/reflect_vector_across_plane_unit.sv]
`timescale 1ns / 1ps
// An accepted input beat passes the front end, shift chain, squares, root chain, divider chain and back end.
// Throughput: one beat per cycle while the output is not stalled; up to 80 beats in flight.
// The length is set by the root chain (31 cells) and the divider chain (29 cells).
// The whole pipeline halts only while a result beat waits under stall.
// Reset (rst_ni low, asynchronous) clears every valid bit; data registers are not reset.
module reflect_vector_across_plane_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] vec_x_i,
  input  logic [31:0] vec_y_i,
  input  logic [31:0] vec_z_i,
  input  logic [31:0] p0_x_i,
  input  logic [31:0] p0_y_i,
  input  logic [31:0] p0_z_i,
  input  logic [31:0] p1_x_i,
  input  logic [31:0] p1_y_i,
  input  logic [31:0] p1_z_i,
  input  logic [31:0] p2_x_i,
  input  logic [31:0] p2_y_i,
  input  logic [31:0] p2_z_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] out_x_o,
  output logic [31:0] out_y_o,
  output logic [31:0] out_z_o,
  output logic        degenerate_o,
  output logic        saturated_o
);
  import rvp_pkg::*;

  localparam logic [D_W-1:0]   D_HALF = D_W'(1) << (NORM_BITS-1);
  localparam logic [U_W+NORM_BITS+1:0] X_HALF = (U_W+NORM_BITS+2)'(1) << (NORM_BITS-1);

  logic en;
  vec3_t in_vec, in_p0, in_p1, in_p2;

  assign in_vec = {vec_z_i, vec_y_i, vec_x_i};
  assign in_p0  = {p0_z_i, p0_y_i, p0_x_i};
  assign in_p1  = {p1_z_i, p1_y_i, p1_x_i};
  assign in_p2  = {p2_z_i, p2_y_i, p2_x_i};

  // -------------------------------------------------------------------
  // Front end: edges, cross products, magnitudes
  // -------------------------------------------------------------------
  logic                       v1_q, v2_q, v3_q, v4_q;
  logic signed [EDGE_W-1:0]   e1_q [3];
  logic signed [EDGE_W-1:0]   e2_q [3];
  logic signed [PROD_W-1:0]   pr_q [6];
  logic signed [CROSS_W-1:0]  c_q  [3];
  logic [2:0][CROSS_W-1:0]    negc_w;
  logic [2:0][MAG_W-1:0]      mag_q;
  vec3_t                      vec1_q, vec2_q, vec3_q;
  side_t                      side4_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      negc_w[i] = -c_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // exact 33-bit edges
      for (int i = 0; i < 3; i++) begin
        e1_q[i] <= $signed({in_p1[i][WORD_W-1], in_p1[i]})
                 - $signed({in_p0[i][WORD_W-1], in_p0[i]});
        e2_q[i] <= $signed({in_p2[i][WORD_W-1], in_p2[i]})
                 - $signed({in_p0[i][WORD_W-1], in_p0[i]});
      end
      vec1_q <= in_vec;
      // edge products, a pair for each cross component
      pr_q[0] <= e1_q[1] * e2_q[2];
      pr_q[1] <= e1_q[2] * e2_q[1];
      pr_q[2] <= e1_q[2] * e2_q[0];
      pr_q[3] <= e1_q[0] * e2_q[2];
      pr_q[4] <= e1_q[0] * e2_q[1];
      pr_q[5] <= e1_q[1] * e2_q[0];
      vec2_q  <= vec1_q;
      // exact cross product
      for (int i = 0; i < 3; i++) begin
        c_q[i] <= CROSS_W'(pr_q[2*i]) - CROSS_W'(pr_q[2*i+1]);
      end
      vec3_q <= vec2_q;
      // sign and magnitude
      for (int i = 0; i < 3; i++) begin
        side4_q.neg[i] <= c_q[i][CROSS_W-1];
        mag_q[i] <= c_q[i][CROSS_W-1] ? negc_w[i][MAG_W-1:0] : MAG_W'(c_q[i]);
      end
      side4_q.deg <= (c_q[0] == '0) && (c_q[1] == '0) && (c_q[2] == '0);
      side4_q.vec <= vec3_q;
    end
  end

  // -------------------------------------------------------------------
  // Block normalisation: shift chain 64, 32, ... 1
  // -------------------------------------------------------------------
  logic [SHIFT_STAGES:0]                    nv;
  logic [SHIFT_STAGES:0][2:0][MAG_W-1:0]    nmag;
  side_t [SHIFT_STAGES:0]                   nside;

  assign nv[0]    = v4_q;
  assign nmag[0]  = mag_q;
  assign nside[0] = side4_q;

  for (genvar k = 0; k < SHIFT_STAGES; k++) begin : g_norm
    rvp_norm_cell #(
      .SHIFT(1 << (SHIFT_STAGES-1-k))
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(nv[k]),
      .mag_i  (nmag[k]),
      .side_i (nside[k]),
      .valid_o(nv[k+1]),
      .mag_o  (nmag[k+1]),
      .side_o (nside[k+1])
    );
  end

  // -------------------------------------------------------------------
  // Squares and their sum
  // -------------------------------------------------------------------
  logic                  v5_q, v6_q;
  logic [2:0][SQ_W-1:0]  sq_q;
  m3_t                   m5_q, m6_q;
  side_t                 side5_q, side6_q;
  logic [Q_W-1:0]        q6_q;
  m3_t                   m_w;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m_w[i] = nmag[SHIFT_STAGES][i][MAG_W-1 -: M_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en) begin
      v5_q <= nv[SHIFT_STAGES];
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= m_w[i] * m_w[i];
      end
      m5_q    <= m_w;
      side5_q <= nside[SHIFT_STAGES];
      q6_q    <= Q_W'(sq_q[0]) + Q_W'(sq_q[1]) + Q_W'(sq_q[2]);
      m6_q    <= m5_q;
      side6_q <= side5_q;
    end
  end

  // -------------------------------------------------------------------
  // Square root chain, one root bit per cell
  // -------------------------------------------------------------------
  logic [SQRT_STEPS:0]               sv;
  logic [SQRT_STEPS:0][Q_W-1:0]      sq_rad;
  logic [SQRT_STEPS:0][REM_W-1:0]    s_rem;
  logic [SQRT_STEPS:0][ROOT_W-1:0]   s_root;
  sq_side_t [SQRT_STEPS:0]           s_side;

  assign sv[0]          = v6_q;
  assign sq_rad[0]      = q6_q;
  assign s_rem[0]       = '0;
  assign s_root[0]      = '0;
  assign s_side[0].base = side6_q;
  assign s_side[0].m    = m6_q;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    rvp_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(sv[k]),
      .q_i    (sq_rad[k]),
      .rem_i  (s_rem[k]),
      .root_i (s_root[k]),
      .side_i (s_side[k]),
      .valid_o(sv[k+1]),
      .q_o    (sq_rad[k+1]),
      .rem_o  (s_rem[k+1]),
      .root_o (s_root[k+1]),
      .side_o (s_side[k+1])
    );
  end

  // -------------------------------------------------------------------
  // Divider chain: n = floor(m * 2^28 / L) on three lanes
  // -------------------------------------------------------------------
  logic [DIV_STEPS:0]                    dv;
  logic [DIV_STEPS:0][ROOT_W-1:0]        d_len;
  logic [DIV_STEPS:0][2:0][DREM_W-1:0]   d_rem;
  logic [DIV_STEPS:0][2:0][QUO_W-1:0]    d_quo;
  logic [DIV_STEPS:0][2:0]               d_bit;
  side_t [DIV_STEPS:0]                   d_side;
  m3_t                                   m_end;

  assign m_end     = s_side[SQRT_STEPS].m;
  assign dv[0]     = sv[SQRT_STEPS];
  assign d_len[0]  = s_root[SQRT_STEPS];
  assign d_side[0] = s_side[SQRT_STEPS].base;
  assign d_quo[0]  = '0;

  for (genvar i = 0; i < 3; i++) begin : g_div_in
    assign d_rem[0][i] = {{(DREM_W-M_W+1){1'b0}}, m_end[i][M_W-1:1]};
    assign d_bit[0][i] = m_end[i][0];
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    rvp_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(dv[k]),
      .len_i  (d_len[k]),
      .rem_i  (d_rem[k]),
      .quo_i  (d_quo[k]),
      .bit_i  (d_bit[k]),
      .side_i (d_side[k]),
      .valid_o(dv[k+1]),
      .len_o  (d_len[k+1]),
      .rem_o  (d_rem[k+1]),
      .quo_o  (d_quo[k+1]),
      .bit_o  (d_bit[k+1]),
      .side_o (d_side[k+1])
    );
  end

  // -------------------------------------------------------------------
  // Back end: signed normal, dot product, reflection, saturation
  // -------------------------------------------------------------------
  logic                     v7_q, v8_q, v9_q, v10_q, v11_q, v12_q, v13_q;
  logic signed [N_W-1:0]    n7_q [3];
  logic signed [N_W-1:0]    n8_q [3];
  logic signed [N_W-1:0]    n9_q [3];
  logic signed [N_W-1:0]    n10_q [3];
  logic signed [DOT_W-1:0]  dp_q [3];
  logic signed [D_W-1:0]    d_q;
  logic signed [S_W-1:0]    s_q;
  logic signed [P_W-1:0]    p_q [3];
  logic signed [U_W-1:0]    u_q [3];
  side_t                    side7_q, side8_q, side9_q, side10_q, side11_q, side12_q;
  logic [N_W-1:0]           a_w [3];
  logic [D_W-1:0]           d_adj_w;
  logic [U_W+NORM_BITS+1:0] x_w [3];
  logic [U_W+NORM_BITS+1:0] x_adj_w [3];
  logic signed [R_W-1:0]    r_w [3];
  logic [2:0]               ovf_w;
  vec3_t                    res_w;
  vec3_t                    out_q;
  logic                     deg_q, sat_q;

  always_comb begin
    d_adj_w = d_q + (d_q[D_W-1] ? (D_HALF - D_W'(1)) : D_HALF);
    for (int i = 0; i < 3; i++) begin
      a_w[i]     = {1'b0, d_quo[DIV_STEPS][i]};
      // 2 * s * n, rounded half away from zero
      x_w[i]     = {p_q[i], 1'b0};
      x_adj_w[i] = x_w[i] + (x_w[i][U_W+NORM_BITS+1] ? (X_HALF - 1'b1) : X_HALF);
      // v - u, then clip to 32 bits
      r_w[i]     = $signed(R_W'($signed(side12_q.vec[i]))) - R_W'(u_q[i]);
      ovf_w[i]   = (r_w[i][R_W-1:WORD_W-1] != '0) && (r_w[i][R_W-1:WORD_W-1] != '1);
      if (ovf_w[i]) begin
        res_w[i] = r_w[i][R_W-1] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
      end else begin
        res_w[i] = r_w[i][WORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q  <= 1'b0;
      v8_q  <= 1'b0;
      v9_q  <= 1'b0;
      v10_q <= 1'b0;
      v11_q <= 1'b0;
      v12_q <= 1'b0;
      v13_q <= 1'b0;
    end else if (en) begin
      v7_q  <= dv[DIV_STEPS];
      v8_q  <= v7_q;
      v9_q  <= v8_q;
      v10_q <= v9_q;
      v11_q <= v10_q;
      v12_q <= v11_q;
      v13_q <= v12_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        n7_q[i]  <= d_side[DIV_STEPS].neg[i] ? -$signed(a_w[i]) : $signed(a_w[i]);
        dp_q[i]  <= $signed(side7_q.vec[i]) * n7_q[i];
        n8_q[i]  <= n7_q[i];
        n9_q[i]  <= n8_q[i];
        n10_q[i] <= n9_q[i];
        p_q[i]   <= s_q * n10_q[i];
        u_q[i]   <= $signed(x_adj_w[i][NORM_BITS +: U_W]);
      end
      side7_q  <= d_side[DIV_STEPS];
      side8_q  <= side7_q;
      d_q      <= D_W'(dp_q[0]) + D_W'(dp_q[1]) + D_W'(dp_q[2]);
      side9_q  <= side8_q;
      s_q      <= $signed(d_adj_w[NORM_BITS +: S_W]);
      side10_q <= side9_q;
      side11_q <= side10_q;
      side12_q <= side11_q;
      // output register
      if (side12_q.deg) begin
        out_q <= side12_q.vec;
        sat_q <= 1'b0;
      end else begin
        out_q <= res_w;
        sat_q <= |ovf_w;
      end
      deg_q <= side12_q.deg;
    end
  end

  // global advance: hold everything only while a result beat is stalled
  assign en         = !(v13_q && out_stall_i);
  assign in_stall_o = !en;

  assign out_valid_o  = v13_q;
  assign out_x_o      = out_q[0];
  assign out_y_o      = out_q[1];
  assign out_z_o      = out_q[2];
  assign degenerate_o = deg_q;
  assign saturated_o  = sat_q;

endmodule

[src/rvp_norm_cell.sv]
`timescale 1ns / 1ps
module rvp_norm_cell #(
  parameter int unsigned SHIFT = 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic [2:0][rvp_pkg::MAG_W-1:0]    mag_i,
  input  rvp_pkg::side_t                    side_i,
  output logic                              valid_o,
  output logic [2:0][rvp_pkg::MAG_W-1:0]    mag_o,
  output rvp_pkg::side_t                    side_o
);
  import rvp_pkg::*;

  logic [MAG_W-1:0]      any_w;
  logic                  hit_w;
  logic [2:0][MAG_W-1:0] mag_d, mag_q;
  side_t                 side_q;
  logic                  valid_q;

  // shift all three left together while the common top bits are clear
  assign any_w = mag_i[0] | mag_i[1] | mag_i[2];
  assign hit_w = (any_w[MAG_W-1 -: SHIFT] == '0);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_d[i] = hit_w ? (mag_i[i] << SHIFT) : mag_i[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q  <= mag_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign mag_o   = mag_q;
  assign side_o  = side_q;

endmodule

[src/rvp_sqrt_cell.sv]
`timescale 1ns / 1ps
module rvp_sqrt_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [rvp_pkg::Q_W-1:0]    q_i,
  input  logic [rvp_pkg::REM_W-1:0]  rem_i,
  input  logic [rvp_pkg::ROOT_W-1:0] root_i,
  input  rvp_pkg::sq_side_t          side_i,
  output logic                       valid_o,
  output logic [rvp_pkg::Q_W-1:0]    q_o,
  output logic [rvp_pkg::REM_W-1:0]  rem_o,
  output logic [rvp_pkg::ROOT_W-1:0] root_o,
  output rvp_pkg::sq_side_t          side_o
);
  import rvp_pkg::*;

  logic [REM_W+1:0]  t_w, trial_w, diff_w;
  logic              ge_w;
  logic [Q_W-1:0]    q_q;
  logic [REM_W-1:0]  rem_q;
  logic [ROOT_W-1:0] root_q;
  sq_side_t          side_q;
  logic              valid_q;

  // one root bit: bring in the next two radicand bits, trial subtract
  assign t_w     = {rem_i, q_i[Q_W-1 -: 2]};
  assign trial_w = {{(REM_W-ROOT_W){1'b0}}, root_i, 2'b01};
  assign diff_w  = t_w - trial_w;
  assign ge_w    = (t_w >= trial_w);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q    <= {q_i[Q_W-3:0], 2'b00};
      rem_q  <= ge_w ? diff_w[REM_W-1:0] : t_w[REM_W-1:0];
      root_q <= {root_i[ROOT_W-2:0], ge_w};
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign q_o     = q_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign side_o  = side_q;

endmodule

[src/rvp_div_cell.sv]
`timescale 1ns / 1ps
module rvp_div_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic [rvp_pkg::ROOT_W-1:0]        len_i,
  input  logic [2:0][rvp_pkg::DREM_W-1:0]   rem_i,
  input  logic [2:0][rvp_pkg::QUO_W-1:0]    quo_i,
  input  logic [2:0]                        bit_i,
  input  rvp_pkg::side_t                    side_i,
  output logic                              valid_o,
  output logic [rvp_pkg::ROOT_W-1:0]        len_o,
  output logic [2:0][rvp_pkg::DREM_W-1:0]   rem_o,
  output logic [2:0][rvp_pkg::QUO_W-1:0]    quo_o,
  output logic [2:0]                        bit_o,
  output rvp_pkg::side_t                    side_o
);
  import rvp_pkg::*;

  logic [2:0][DREM_W:0]   t_w, diff_w;
  logic [2:0]             ge_w;
  logic [2:0][DREM_W-1:0] rem_d, rem_q;
  logic [2:0][QUO_W-1:0]  quo_d, quo_q;
  logic [ROOT_W-1:0]      len_q;
  side_t                  side_q;
  logic                   valid_q;

  // one quotient bit for each of the three lanes
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t_w[i]    = {rem_i[i], bit_i[i]};
      diff_w[i] = t_w[i] - {1'b0, len_i};
      ge_w[i]   = (t_w[i] >= {1'b0, len_i});
      rem_d[i]  = ge_w[i] ? diff_w[i][DREM_W-1:0] : t_w[i][DREM_W-1:0];
      quo_d[i]  = {quo_i[i][QUO_W-2:0], ge_w[i]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      len_q  <= len_i;
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign len_o   = len_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;
  assign bit_o   = 3'b000;  // dividend is m << 28: only zeros follow
  assign side_o  = side_q;

endmodule

[src/rvp_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rvp_port_props (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] out_x_o,
  input logic        degenerate_o,
  input logic        saturated_o
);

  // a stalled result beat stays
  `ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  // and keeps its x payload
  `ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(out_x_o))
  // input side is held back only by a stalled result
  `ASSERT_IMP(a_in_stall, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)
  // a degenerate plane passes the vector through unclipped
  `ASSERT_IMP(a_deg_nosat, clk_i, rst_ni, out_valid_o && degenerate_o, !saturated_o)

endmodule

bind reflect_vector_across_plane_unit rvp_port_props u_rvp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_x_o     (out_x_o),
  .degenerate_o(degenerate_o),
  .saturated_o (saturated_o)
);
